[sv/mfl_pkg.sv]
package mfl_pkg;

    localparam int CFG_W   = 5;
    localparam int VTX_W   = 4;
    localparam int CAPIN_W = 10;
    localparam int OUT_W   = 16;

    localparam logic [CFG_W-1:0] VCOUNT_RESET = 5'd16;
    localparam int               SOURCE_LIMIT = 1000;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } t_opcode;

endpackage

[sv/max_flow_labeling.sv]
// max flow by labeling, source vertex 0, sink vertex vertex_count-1
// command port: an item is taken when start is high and busy is low
//   opcode load writes one capacity entry in that cycle, busy stays low,
//   so loads go at one item per cycle
//   opcode run computes the max flow and the source side of the min cut
// result: o_done pulses for one cycle with o_max_flow and o_cut_mask;
// there is no back pressure on the result
// a run clears the flow memory, then per search scans for a labeled vertex,
//   reads both directions of each neighbor of each examined vertex and
//   reads and writes the flow of each edge of each augmenting path;
//   finally it sums the flow out of the source
// everything goes through one sequencer, capacity and flow memories sharing
// one read address and one compare/subtract datapath, so busy stays high all run
// the user must write vertex_count through i_cfg_we / i_cfg_wdata only while idle; not enforced
// after reset the capacity and flow memories are cleared with busy high,
// and vertex_count returns to 16
module max_flow_labeling #(
    parameter int VERTICES = 16,
    parameter int CAP_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_opcode,
    input  logic [mfl_pkg::VTX_W-1:0]    i_from_vertex,
    input  logic [mfl_pkg::VTX_W-1:0]    i_to_vertex,
    input  logic [mfl_pkg::CAPIN_W-1:0]  i_capacity,
    input  logic                         i_cfg_we,
    input  logic [mfl_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                         o_done,
    output logic [mfl_pkg::OUT_W-1:0]    o_max_flow,
    output logic [mfl_pkg::OUT_W-1:0]    o_cut_mask
);

    localparam int VW    = $clog2(VERTICES);
    localparam int AW    = 2 * VW;
    localparam int IW    = (CAP_BITS > 10) ? CAP_BITS : 10;
    localparam int MB    = (VERTICES < mfl_pkg::OUT_W) ? VERTICES : mfl_pkg::OUT_W;
    localparam int NCW   = 8;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_FCLR, S_SCAN, S_EX_F, S_EX_R, S_EX_E, S_EX_END,
        S_AUG_RD, S_AUG_WR, S_SUM_RD, S_SUM_ACC
    } t_state;

    t_state r_state;

    logic [mfl_pkg::CFG_W-1:0] r_vcount;
    logic [AW-1:0]             r_addr;
    logic [VW-1:0]             r_last;
    logic [VW-1:0]             r_scan;
    logic [VW-1:0]             r_v;
    logic [VW-1:0]             r_j;
    logic [IW-1:0]             r_inc_v;
    logic [CAP_BITS-1:0]       r_cf;
    logic [CAP_BITS-1:0]       r_ff;
    logic [VW-1:0]             r_idx;
    logic [VW-1:0]             r_steps;
    logic [VW-1:0]             r_p;
    logic                      r_aug_rev;
    logic [AW-1:0]             r_aug_addr;
    logic [CAP_BITS-1:0]       r_aug_inc;
    logic [mfl_pkg::OUT_W-1:0] r_acc;

    logic [VERTICES-1:0]       r_marked;
    logic [VERTICES-1:0]       r_checked;
    logic [VERTICES-1:0]       r_rev;
    logic [VW-1:0]             r_pred [VERTICES];
    logic [IW-1:0]             r_pinc [VERTICES];

    logic                cap_we;
    logic [AW-1:0]       cap_waddr;
    logic [CAP_BITS-1:0] cap_wdata;
    logic [CAP_BITS-1:0] cap_rd;
    logic                flow_we;
    logic [AW-1:0]       flow_waddr;
    logic [CAP_BITS-1:0] flow_wdata;
    logic [CAP_BITS-1:0] flow_rd;
    logic [AW-1:0]       rd_addr;

    logic [NCW-1:0] ld_from;
    logic [NCW-1:0] ld_to;
    logic           ld_ok;
    logic           take;
    logic [NCW-1:0] ncl;
    logic [VW-1:0]  pred_idx;
    logic           rev_idx;
    logic [AW-1:0]  aug_addr;
    logic [IW-1:0]  pinc_rd;
    logic [VW-1:0]  pinc_sel;
    logic [IW-1:0]  fwd_res;
    logic [IW-1:0]  fwd_inc;
    logic [IW-1:0]  rev_inc;
    logic [mfl_pkg::OUT_W-1:0] acc_next;
    logic [mfl_pkg::OUT_W-1:0] cut;

    assign busy = (r_state != S_IDLE);
    assign take = start && !busy;

    assign ld_from = NCW'(i_from_vertex);
    assign ld_to   = NCW'(i_to_vertex);
    assign ld_ok   = (ld_from < NCW'(VERTICES)) && (ld_to < NCW'(VERTICES));

    // clamp vertex count into 2..VERTICES
    always_comb begin
        priority if (r_vcount < 5'd2) begin
            ncl = NCW'(2);
        end else if (NCW'(r_vcount) > NCW'(VERTICES)) begin
            ncl = NCW'(VERTICES);
        end else begin
            ncl = NCW'(r_vcount);
        end
    end

    assign pred_idx = r_pred[r_idx];
    assign rev_idx  = r_rev[r_idx];
    assign aug_addr = rev_idx ? {r_idx, pred_idx} : {pred_idx, r_idx};
    assign pinc_sel = (r_state == S_EX_END) ? r_last : r_scan;
    assign pinc_rd  = r_pinc[pinc_sel];

    assign fwd_res = IW'(r_cf - r_ff);
    assign fwd_inc = (r_inc_v < fwd_res) ? r_inc_v : fwd_res;
    assign rev_inc = (r_inc_v < IW'(flow_rd)) ? r_inc_v : IW'(flow_rd);
    assign acc_next = r_acc + mfl_pkg::OUT_W'(flow_rd);

    always_comb begin
        cut = '0;
        for (int i = 0; i < MB; i++) begin
            cut[i] = r_marked[i] && (VW'(i) <= r_last);
        end
    end

    always_comb begin
        cap_we    = 1'b0;
        cap_waddr = {ld_from[VW-1:0], ld_to[VW-1:0]};
        cap_wdata = CAP_BITS'(i_capacity);
        if (r_state == S_CLR) begin
            cap_we    = 1'b1;
            cap_waddr = r_addr;
            cap_wdata = '0;
        end else if (take && (i_opcode == mfl_pkg::OP_LOAD) && ld_ok) begin
            cap_we = 1'b1;
        end
    end

    always_comb begin
        flow_we    = (r_state == S_CLR) || (r_state == S_FCLR) || (r_state == S_AUG_WR);
        flow_waddr = r_addr;
        flow_wdata = '0;
        if (r_state == S_AUG_WR) begin
            flow_waddr = r_aug_addr;
            flow_wdata = r_aug_rev ? (flow_rd - r_aug_inc) : (flow_rd + r_aug_inc);
        end
    end

    always_comb begin
        unique case (r_state)
            S_EX_F:   rd_addr = {r_v, r_j};
            S_EX_R:   rd_addr = {r_j, r_v};
            S_AUG_RD: rd_addr = aug_addr;
            S_SUM_RD: rd_addr = {{VW{1'b0}}, r_j};
            default:  rd_addr = '0;
        endcase
    end

    mfl_ram #(.WIDTH(CAP_BITS), .DEPTH(1 << AW)) u_cap_ram (
        .i_clk   (i_clk),
        .i_we    (cap_we),
        .i_waddr (cap_waddr),
        .i_wdata (cap_wdata),
        .i_raddr (rd_addr),
        .o_rdata (cap_rd)
    );

    mfl_ram #(.WIDTH(CAP_BITS), .DEPTH(1 << AW)) u_flow_ram (
        .i_clk   (i_clk),
        .i_we    (flow_we),
        .i_waddr (flow_waddr),
        .i_wdata (flow_wdata),
        .i_raddr (rd_addr),
        .o_rdata (flow_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_vcount  <= mfl_pkg::VCOUNT_RESET;
            r_addr    <= '0;
            r_marked  <= VERTICES'(1);
            r_checked <= '0;
            r_rev     <= '0;
            r_pinc[0] <= IW'(mfl_pkg::SOURCE_LIMIT);
            r_pred[0] <= '0;
            o_done    <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            unique case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (take && (i_opcode == mfl_pkg::OP_RUN)) begin
                        r_last    <= VW'(ncl - 1'b1);
                        r_addr    <= '0;
                        r_marked  <= VERTICES'(1);
                        r_checked <= '0;
                        r_pinc[0] <= IW'(mfl_pkg::SOURCE_LIMIT);
                        r_pred[0] <= '0;
                        r_state   <= S_FCLR;
                    end
                end
                S_FCLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == '1) begin
                        r_scan  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // lowest marked vertex not yet examined
                    if (r_marked[r_scan] && !r_checked[r_scan]) begin
                        r_v                <= r_scan;
                        r_inc_v            <= pinc_rd;
                        r_checked[r_scan]  <= 1'b1;
                        r_j                <= '0;
                        r_state            <= S_EX_F;
                    end else if (r_scan == r_last) begin
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_state <= S_SUM_RD;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_EX_F: begin
                    r_state <= S_EX_R;
                end
                S_EX_R: begin
                    r_cf    <= cap_rd;
                    r_ff    <= flow_rd;
                    r_state <= S_EX_E;
                end
                S_EX_E: begin
                    if (!r_marked[r_j]) begin
                        if (r_cf > r_ff) begin
                            r_marked[r_j] <= 1'b1;
                            r_pred[r_j]   <= r_v;
                            r_pinc[r_j]   <= fwd_inc;
                            r_rev[r_j]    <= 1'b0;
                        end else if ((cap_rd != '0) && (flow_rd != '0)) begin
                            r_marked[r_j] <= 1'b1;
                            r_pred[r_j]   <= r_v;
                            r_pinc[r_j]   <= rev_inc;
                            r_rev[r_j]    <= 1'b1;
                        end
                    end
                    if (r_j == r_last) begin
                        r_state <= S_EX_END;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_EX_F;
                    end
                end
                S_EX_END: begin
                    if (r_marked[r_last]) begin
                        r_idx     <= r_last;
                        r_steps   <= '0;
                        r_aug_inc <= CAP_BITS'(pinc_rd);
                        r_state   <= S_AUG_RD;
                    end else begin
                        r_scan  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_AUG_RD: begin
                    r_p        <= pred_idx;
                    r_aug_rev  <= rev_idx;
                    r_aug_addr <= aug_addr;
                    r_state    <= S_AUG_WR;
                end
                S_AUG_WR: begin
                    r_idx   <= r_p;
                    r_steps <= r_steps + 1'b1;
                    if ((r_p != '0) && (r_steps < r_last)) begin
                        r_state <= S_AUG_RD;
                    end else begin
                        // path done, restart labels from the source
                        r_marked  <= VERTICES'(1);
                        r_checked <= '0;
                        r_pinc[0] <= IW'(mfl_pkg::SOURCE_LIMIT);
                        r_pred[0] <= '0;
                        r_scan    <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SUM_RD: begin
                    r_state <= S_SUM_ACC;
                end
                S_SUM_ACC: begin
                    r_acc <= acc_next;
                    if (r_j == r_last) begin
                        o_done     <= 1'b1;
                        o_max_flow <= acc_next;
                        o_cut_mask <= cut;
                        r_state    <= S_IDLE;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_SUM_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[sv/mfl_ram.sv]
module mfl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[sv/mfl_checker.sv]
module mfl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_opcode,
    input logic        o_done,
    input logic [15:0] o_cut_mask
);

    // a finished run always has the source labeled
    a_src_in_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_cut_mask[0])
        else $error("source missing from cut mask");

    // a load never blocks the next item
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == mfl_pkg::OP_LOAD)) |=> !busy)
        else $error("load item left the block busy");

    // a run occupies the block
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == mfl_pkg::OP_RUN)) |=> (busy && !o_done))
        else $error("run item did not hold busy");

    // a result only comes at the end of a busy run
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe outside a run end");

    // reset starts the memory clear
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_done))
        else $error("reset did not start the clear sweep");

endmodule

bind max_flow_labeling mfl_checker u_mfl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_opcode   (i_opcode),
    .o_done     (o_done),
    .o_cut_mask (o_cut_mask)
);

[tb/max_flow_checker.sv]
`timescale 1ns / 100ps

module max_flow_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         i_opcode,
    input  logic [mfl_pkg::VTX_W-1:0]    i_from_vertex,
    input  logic [mfl_pkg::VTX_W-1:0]    i_to_vertex,
    input  logic [mfl_pkg::CAPIN_W-1:0]  i_capacity,
    input  logic                         i_cfg_we,
    input  logic [mfl_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                         o_done,
    input  logic [mfl_pkg::OUT_W-1:0]    o_max_flow,
    input  logic [mfl_pkg::OUT_W-1:0]    o_cut_mask,
    output int                           o_errors,
    output int                           o_pending,
    output logic                         o_activity
);

    localparam int NV = 16;

    typedef struct packed {
        logic [mfl_pkg::OUT_W-1:0] flow;
        logic [mfl_pkg::OUT_W-1:0] cut;
    } t_cut_result;

    logic [mfl_pkg::CAPIN_W-1:0] cap_mem [NV*NV];
    logic [mfl_pkg::CFG_W-1:0]   vcount;
    t_cut_result                 expected_cuts [4];
    int                          wr_cnt = 0;
    int                          rd_cnt = 0;

    function automatic t_cut_result solve_flow(logic [mfl_pkg::CFG_W-1:0] cnt);
        int          n, v, j, idx, steps, p;
        int unsigned flw [NV*NV];
        bit          lab [NV];
        bit          seen [NV];
        bit          back [NV];
        int unsigned pred [NV];
        int unsigned incr [NV];
        int unsigned cf, ff, cr, fr, amt, tot;
        t_cut_result r;
        n = cnt;
        if (n < 2) n = 2;
        if (n > NV) n = NV;
        foreach (flw[k]) flw[k] = 0;
        foreach (lab[k]) begin
            lab[k] = 0; seen[k] = 0; back[k] = 0; pred[k] = 0; incr[k] = 0;
        end
        lab[0] = 1;
        incr[0] = mfl_pkg::SOURCE_LIMIT;
        while (1) begin
            v = 0;
            while (v < n && !(lab[v] && !seen[v])) v++;
            if (v == n) break;
            seen[v] = 1;
            for (j = 0; j < n; j++) begin
                cf = cap_mem[v*NV+j];
                ff = flw[v*NV+j];
                cr = cap_mem[j*NV+v];
                fr = flw[j*NV+v];
                if (cf > 0 && !lab[j] && cf > ff) begin
                    lab[j] = 1; pred[j] = v; back[j] = 0;
                    incr[j] = (incr[v] < cf - ff) ? incr[v] : cf - ff;
                end
                if (cr > 0 && !lab[j] && fr > 0) begin
                    lab[j] = 1; pred[j] = v; back[j] = 1;
                    incr[j] = (incr[v] < fr) ? incr[v] : fr;
                end
            end
            if (lab[n-1]) begin
                // push the bottleneck back along the labeled path
                amt = incr[n-1];
                idx = n - 1;
                steps = 0;
                while (idx != 0 && steps < n) begin
                    p = pred[idx] % NV;
                    if (back[idx]) flw[idx*NV+p] -= amt;
                    else flw[p*NV+idx] += amt;
                    idx = p;
                    steps++;
                end
                foreach (lab[k]) begin
                    lab[k] = 0; seen[k] = 0;
                end
                lab[0] = 1;
                pred[0] = 0;
                incr[0] = mfl_pkg::SOURCE_LIMIT;
            end
        end
        tot = 0;
        r.cut = '0;
        for (v = 0; v < n; v++) begin
            tot += flw[v];
            if (lab[v]) r.cut[v] = 1'b1;
        end
        r.flow = tot[mfl_pkg::OUT_W-1:0];
        return r;
    endfunction

    assign o_pending = wr_cnt - rd_cnt;

    always @(posedge i_clk) begin
        t_cut_result want;
        o_activity <= 1'b0;
        if (!i_rst_n) begin
            foreach (cap_mem[k]) cap_mem[k] <= '0;
            vcount <= mfl_pkg::VCOUNT_RESET;
        end else begin
            if (i_cfg_we) vcount <= i_cfg_wdata;
            if (start && !busy) begin
                o_activity <= 1'b1;
                if (mfl_pkg::t_opcode'(i_opcode) == mfl_pkg::OP_LOAD) begin
                    cap_mem[{i_from_vertex, i_to_vertex}] <= i_capacity;
                end else begin
                    expected_cuts[wr_cnt[1:0]] = solve_flow(vcount);
                    wr_cnt = wr_cnt + 1;
                end
            end
            if (o_done) begin
                o_activity <= 1'b1;
                if (wr_cnt == rd_cnt) begin
                    o_errors <= o_errors + 1;
                    $display("%0t: unexpected result flow %0d cut %h", $time,
                             o_max_flow, o_cut_mask);
                end else begin
                    want = expected_cuts[rd_cnt[1:0]];
                    rd_cnt = rd_cnt + 1;
                    if (want.flow !== o_max_flow || want.cut !== o_cut_mask) begin
                        o_errors <= o_errors + 1;
                        $display("%0t: expected flow %0d cut %h, got flow %0d cut %h",
                                 $time, want.flow, want.cut, o_max_flow, o_cut_mask);
                    end
                end
            end
        end
    end

    initial o_errors = 0;

endmodule

[tb/max_flow_labeling_tb.sv]
`timescale 1ns / 100ps

module max_flow_labeling_tb;

    localparam int WATCHDOG_LIMIT = 70000000;
    localparam int ITEM_TARGET    = 1700;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic                         i_opcode = mfl_pkg::OP_LOAD;
    logic [mfl_pkg::VTX_W-1:0]    i_from_vertex = '0;
    logic [mfl_pkg::VTX_W-1:0]    i_to_vertex = '0;
    logic [mfl_pkg::CAPIN_W-1:0]  i_capacity = '0;
    logic                         i_cfg_we = 1'b0;
    logic [mfl_pkg::CFG_W-1:0]    i_cfg_wdata = '0;
    logic                         o_done;
    logic [mfl_pkg::OUT_W-1:0]    o_max_flow;
    logic [mfl_pkg::OUT_W-1:0]    o_cut_mask;
    int                           errors, pending;
    logic                         activity;
    logic                         busy_seen;
    int                           quiet_cycles = 0;
    int                           items_sent = 0;
    bit                           idling_on = 1'b1;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    max_flow_labeling u_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_opcode, .i_from_vertex, .i_to_vertex,
        .i_capacity, .i_cfg_we, .i_cfg_wdata, .o_done, .o_max_flow, .o_cut_mask
    );

    max_flow_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_opcode, .i_from_vertex, .i_to_vertex,
        .i_capacity, .i_cfg_we, .i_cfg_wdata, .o_done, .o_max_flow, .o_cut_mask,
        .o_errors(errors), .o_pending(pending), .o_activity(activity)
    );

    // busy only moves at the rising edge, so this is its value at the next one
    always @(negedge i_clk) busy_seen <= busy;

    always @(posedge i_clk) begin
        if (activity || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(mfl_pkg::t_opcode op, int from_v, int to_v, int cap);
        i_opcode      <= op;
        i_from_vertex <= from_v[mfl_pkg::VTX_W-1:0];
        i_to_vertex   <= to_v[mfl_pkg::VTX_W-1:0];
        i_capacity    <= cap[mfl_pkg::CAPIN_W-1:0];
        start         <= 1'b1;
        do @(posedge i_clk); while (busy_seen);
        items_sent++;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic load_edge(int from_v, int to_v, int cap);
        send_item(mfl_pkg::OP_LOAD, from_v, to_v, cap);
    endtask

    task automatic run_flow();
        send_item(mfl_pkg::OP_RUN, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 1023));
    endtask

    // item loads cause no result, so the block is given idle time after draining
    task automatic set_vertex_count(int cnt);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy_seen) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cnt[mfl_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_cap();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1023;
            2:       return $urandom_range(0, 1023);
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    initial begin
        int n, span, loads;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: two-vertex graph, full capacity, max vertex indexes
        set_vertex_count(2);
        load_edge(0, 1, 1023);
        run_flow();
        load_edge(0, 1, 0);
        run_flow();
        set_vertex_count(16);
        load_edge(0, 15, 1023);
        load_edge(15, 15, 1023);
        load_edge(0, 7, 600);
        load_edge(7, 15, 700);
        run_flow();
        run_flow();
        // two paths 0-1-3, 0-2-3 with cross edges 1-2 and 2-1
        set_vertex_count(4);
        load_edge(0, 1, 10);
        load_edge(0, 2, 10);
        load_edge(1, 2, 10);
        load_edge(1, 3, 10);
        load_edge(2, 3, 10);
        load_edge(2, 1, 5);
        run_flow();
        // out of range counts clamp
        set_vertex_count(0);
        run_flow();
        set_vertex_count(1);
        run_flow();
        set_vertex_count(31);
        run_flow();
        set_vertex_count(17);
        run_flow();

        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET - 250) idling_on = 1'b0;
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(0, 31);
                1:       n = 16;
                default: n = $urandom_range(2, 8);
            endcase
            set_vertex_count(n);
            span = (n < 2) ? 2 : (n > 16 ? 16 : n);
            loads = $urandom_range(4, 30);
            repeat (loads) begin
                if ($urandom_range(0, 7) == 0)
                    load_edge($urandom_range(0, 15), $urandom_range(0, 15), pick_cap());
                else
                    load_edge($urandom_range(0, span - 1), $urandom_range(0, span - 1),
                              pick_cap());
            end
            repeat ($urandom_range(1, 2)) run_flow();
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy_seen) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
sv/mfl_pkg.sv
sv/mfl_ram.sv
sv/max_flow_labeling.sv
sv/mfl_checker.sv
tb/max_flow_checker.sv
tb/max_flow_labeling_tb.sv
